>>> design/lpc_autocorrelation_analysis_macros.svh
// assertion macros shared by the checker files
`ifndef LPC_AUTOCORRELATION_ANALYSIS_MACROS_SVH
`define LPC_AUTOCORRELATION_ANALYSIS_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPCAC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LPCAC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds while reset is high
`define LPCAC_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lpcac_pkg.sv
`timescale 1ns / 1ps
package lpcac_pkg;

  localparam int ORDER_MAX  = 16;
  localparam int LAGS       = ORDER_MAX + 1;
  localparam int IDX_W      = 5;
  localparam int HIST_IDX_W = 4;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int SUM_W      = 48;
  localparam int COEF_W     = 32;
  localparam int RES_W      = 31;
  localparam int QUOT_W     = 31;
  localparam int SHIFT_W    = 5;
  localparam int ADDR_W     = 3;
  localparam int REG_W      = 32;

  localparam logic [IDX_W-1:0]  ORDER_RESET = 5'd10;
  localparam logic [IDX_W-1:0]  ORDER_TOP   = 5'd16;
  localparam logic [COEF_W-1:0] ONE_Q24     = 32'h0100_0000;
  localparam logic [RES_W-1:0]  ONE_Q30     = 31'h4000_0000;

  // register index decoded from paddr[2]
  localparam logic REG_ORDER = 1'b0;

  // finished frame handed from front to back
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] order;
  } job_t;

endpackage

>>> design/lpcac_ram.sv
`timescale 1ns / 1ps
module lpcac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> design/lpcac_div.sv
`timescale 1ns / 1ps
module lpcac_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [lpcac_pkg::QUOT_W-1:0]     num,
  input  logic [lpcac_pkg::QUOT_W-1:0]     den,
  output logic                             done,
  output logic [lpcac_pkg::QUOT_W-1:0]     quot
);

  logic                           busy;
  logic [lpcac_pkg::IDX_W-1:0]    cnt;
  logic [lpcac_pkg::QUOT_W:0]     rem;
  logic [lpcac_pkg::QUOT_W-1:0]   dreg;
  logic                           ge;
  logic [lpcac_pkg::QUOT_W:0]     diff;

  // restoring step: num <= den, so quotient is num * 2^30 / den
  assign ge   = rem >= {1'b0, dreg};
  assign diff = ge ? rem - {1'b0, dreg} : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= {1'b0, num};
        dreg <= den;
        quot <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= {diff[lpcac_pkg::QUOT_W-1:0], 1'b0};
        quot <= {quot[lpcac_pkg::QUOT_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == 5'(lpcac_pkg::QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/lpcac_front.sv
`timescale 1ns / 1ps
module lpcac_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [lpcac_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 frame_end,
  input  logic [lpcac_pkg::IDX_W-1:0]          order,
  output lpcac_pkg::job_t                      job,
  input  logic                                 job_done,
  input  logic [lpcac_pkg::IDX_W-1:0]          lag_idx,
  output logic signed [lpcac_pkg::SUM_W-1:0]   lag_data
);

  typedef enum logic [1:0] {F_IDLE, F_MAC, F_LAST, F_HAND} fstate_t;

  fstate_t                                 state;
  logic signed [lpcac_pkg::SAMPLE_W-1:0]   x;
  logic                                    fend;
  logic                                    in_frame;
  logic [lpcac_pkg::IDX_W-1:0]             k;
  logic signed [lpcac_pkg::PROD_W-1:0]     prod;
  logic [lpcac_pkg::IDX_W-1:0]             prod_k;
  logic                                    prod_valid;
  logic signed [lpcac_pkg::SAMPLE_W-1:0]   hist [lpcac_pkg::ORDER_MAX];
  logic signed [lpcac_pkg::SUM_W-1:0]      sums [lpcac_pkg::LAGS];
  logic signed [lpcac_pkg::SUM_W-1:0]      slot_sums [lpcac_pkg::LAGS];
  logic                                    slot_valid;
  logic [lpcac_pkg::IDX_W-1:0]             slot_p;
  logic signed [lpcac_pkg::SAMPLE_W-1:0]   operand;
  logic [lpcac_pkg::HIST_IDX_W-1:0]        hist_idx;
  logic signed [lpcac_pkg::SUM_W:0]        sum_ext;
  logic signed [lpcac_pkg::SUM_W-1:0]      sum_sat;
  logic [lpcac_pkg::IDX_W-1:0]             order_clip;

  // lag operand: the sample itself for lag 0, else the history tap
  assign hist_idx = lpcac_pkg::HIST_IDX_W'(k - 1'b1);
  assign operand  = (k == '0) ? x : hist[hist_idx];

  // saturating 48-bit accumulate of the registered product
  assign sum_ext = {sums[prod_k][lpcac_pkg::SUM_W-1], sums[prod_k]}
                 + {{(lpcac_pkg::SUM_W + 1 - lpcac_pkg::PROD_W){prod[lpcac_pkg::PROD_W-1]}},
                    prod};
  always_comb begin
    if (sum_ext[lpcac_pkg::SUM_W] != sum_ext[lpcac_pkg::SUM_W-1]) begin
      sum_sat = sum_ext[lpcac_pkg::SUM_W] ? {1'b1, {(lpcac_pkg::SUM_W-1){1'b0}}}
                                          : {1'b0, {(lpcac_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[lpcac_pkg::SUM_W-1:0];
    end
  end

  assign order_clip = (order > lpcac_pkg::ORDER_TOP) ? lpcac_pkg::ORDER_TOP : order;

  assign full      = (state != F_IDLE);
  assign job.valid = slot_valid;
  assign job.order = slot_p;
  assign lag_data  = slot_sums[lag_idx];

  // sample sequencer: one lag per cycle through the shared multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      in_frame   <= 1'b0;
      slot_valid <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= 1'b0;
      if (prod_valid) begin
        sums[prod_k] <= sum_sat;
      end
      if (job_done) begin
        slot_valid <= 1'b0;
      end
      unique case (state)
        F_IDLE: begin
          if (push) begin
            x     <= sample;
            fend  <= frame_end;
            k     <= '0;
            state <= F_MAC;
            if (!in_frame) begin
              for (int m = 0; m < lpcac_pkg::ORDER_MAX; m++) hist[m] <= '0;
              for (int m = 0; m < lpcac_pkg::LAGS; m++) sums[m] <= '0;
            end
          end
        end
        F_MAC: begin
          prod       <= x * operand;
          prod_k     <= k;
          prod_valid <= 1'b1;
          if (k == lpcac_pkg::ORDER_TOP) begin
            state <= F_LAST;
          end else begin
            k <= k + 1'b1;
          end
        end
        F_LAST: begin
          hist[0] <= x;
          for (int m = 1; m < lpcac_pkg::ORDER_MAX; m++) hist[m] <= hist[m-1];
          in_frame <= !fend;
          state    <= fend ? F_HAND : F_IDLE;
        end
        F_HAND: begin
          if (!slot_valid) begin
            for (int m = 0; m < lpcac_pkg::LAGS; m++) slot_sums[m] <= sums[m];
            slot_p     <= order_clip;
            slot_valid <= 1'b1;
            state      <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> design/lpcac_back.sv
`timescale 1ns / 1ps
module lpcac_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lpcac_pkg::job_t                      job,
  output logic                                 job_done,
  output logic [lpcac_pkg::IDX_W-1:0]          lag_idx,
  input  logic signed [lpcac_pkg::SUM_W-1:0]   lag_data,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [lpcac_pkg::COEF_W-1:0]  coefficient,
  output logic [lpcac_pkg::IDX_W-1:0]          coeff_index,
  output logic [lpcac_pkg::RES_W-1:0]          residual_error,
  output logic                                 status,
  output logic                                 last_result
);

  typedef enum logic [4:0] {
    B_IDLE, B_NORM, B_RN_START, B_RN_WAIT, B_ACC_INIT, B_ACC_RD, B_ACC_MUL,
    B_ACC_ADD, B_K_START, B_K_WAIT, B_UPD_RD, B_UPD_MUL, B_UPD_ADD, B_KI,
    B_E1, B_E2, B_OUT, B_OUT_LD, B_FAIL
  } bstate_t;

  localparam int CW = lpcac_pkg::COEF_W;
  localparam int SW = lpcac_pkg::SUM_W;
  localparam int IW = lpcac_pkg::IDX_W;
  localparam int RW = lpcac_pkg::RES_W;
  localparam int QW = lpcac_pkg::QUOT_W;

  bstate_t                    state;
  logic [IW-1:0]              p;
  logic [IW-1:0]              i;
  logic [IW-1:0]              j;
  logic [IW-1:0]              o;
  logic [SW-1:0]              d;
  logic [lpcac_pkg::SHIFT_W-1:0] s;
  logic signed [CW-1:0]       rn [lpcac_pkg::LAGS];
  logic signed [SW-1:0]       acc;
  logic                       neg;
  logic signed [CW-1:0]       k;
  logic signed [2*CW-1:0]     prod;
  logic signed [CW-1:0]       areg;
  logic [2*RW-1:0]            pe;
  logic [RW-1:0]              e;
  logic                       bank;
  logic                       out_valid;
  logic                       div_start;
  logic [QW-1:0]              div_num;
  logic [QW-1:0]              div_den;
  logic                       div_done;
  logic [QW-1:0]              div_quot;

  logic [SW-1:0]              lag_mag;
  logic [SW-1:0]              lag_sh;
  logic [SW-1:0]              lag_clamp;
  logic [IW-1:0]              rn_idx;
  logic signed [CW-1:0]       rn_rd;
  logic [SW-1:0]              acc_mag;
  logic signed [SW-1:0]       acc_add;
  logic signed [CW+2:0]       upd_sum;
  logic signed [CW-1:0]       upd_sat;
  logic [RW-1:0]              omk;
  logic signed [CW-1:0]       q_ext;
  logic                       first_fail;
  logic                       ram_we;
  logic [IW-1:0]              waddr;
  logic [CW-1:0]              wdata;
  logic [IW-1:0]              raddr_a;
  logic [IW-1:0]              raddr_b;
  logic [CW-1:0]              ram0_a;
  logic [CW-1:0]              ram0_b;
  logic [CW-1:0]              ram1_a;
  logic [CW-1:0]              ram1_b;
  logic signed [CW-1:0]       rd_a;
  logic signed [CW-1:0]       rd_b;

  // lag normalization path
  assign lag_idx   = (state == B_IDLE) ? '0 : i;
  assign lag_mag   = lag_data[SW-1] ? SW'(-lag_data) : lag_data;
  assign lag_sh    = lag_mag >> s;
  assign lag_clamp = (lag_sh > d) ? d : lag_sh;

  // single read port on the normalized lags
  assign rn_idx = (state == B_ACC_INIT) ? i : IW'(i - j);
  assign rn_rd  = rn[rn_idx];

  // recursion arithmetic
  assign acc_mag = acc[SW-1] ? SW'(-acc) : acc;
  assign acc_add = acc + {{(SW - 40){prod[2*CW-1]}}, prod[2*CW-1:24]};
  assign upd_sum = {{3{areg[CW-1]}}, areg} + {prod[2*CW-1], prod[2*CW-1:30]};
  always_comb begin
    if (upd_sum[CW+2:CW-1] != '0 && upd_sum[CW+2:CW-1] != '1) begin
      upd_sat = upd_sum[CW+2] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      upd_sat = upd_sum[CW-1:0];
    end
  end
  assign omk   = lpcac_pkg::ONE_Q30 - {1'b0, prod[59:30]};
  assign q_ext = {1'b0, div_quot};

  assign first_fail = (job.order == '0) || lag_data[SW-1] || (lag_data == '0);
  assign job_done   = (state == B_IDLE && job.valid && first_fail)
                   || (state == B_RN_WAIT && div_done && i == p);

  // coefficient banks: read old bank, write the other
  assign ram_we  = (state == B_UPD_ADD) || (state == B_KI);
  assign waddr   = (state == B_KI) ? i : j;
  assign wdata   = (state == B_KI) ? CW'(k >>> 6) : upd_sat;
  assign raddr_a = (state == B_OUT) ? o : j;
  assign raddr_b = IW'(i - j);
  assign rd_a    = bank ? ram1_a : ram0_a;
  assign rd_b    = bank ? ram1_b : ram0_b;

  lpcac_ram #(.WIDTH(CW), .DEPTH(lpcac_pkg::LAGS)) u_ram0 (
    .clk     (clk),
    .we      (ram_we && bank),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (ram0_a),
    .raddr_b (raddr_b),
    .rdata_b (ram0_b)
  );

  lpcac_ram #(.WIDTH(CW), .DEPTH(lpcac_pkg::LAGS)) u_ram1 (
    .clk     (clk),
    .we      (ram_we && !bank),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (ram1_a),
    .raddr_b (raddr_b),
    .rdata_b (ram1_b)
  );

  lpcac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign empty = !out_valid;

  // recursion sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      bank      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job.valid) begin
            p <= job.order;
            if (first_fail) begin
              state <= B_FAIL;
            end else begin
              d     <= lag_data;
              s     <= '0;
              state <= B_NORM;
            end
          end
        end
        B_NORM: begin
          if (d[SW-1:QW] != '0) begin
            d <= d >> 1;
            s <= s + 1'b1;
          end else begin
            i     <= IW'(1);
            state <= B_RN_START;
          end
        end
        B_RN_START: begin
          div_num   <= lag_clamp[QW-1:0];
          div_den   <= d[QW-1:0];
          div_start <= 1'b1;
          neg       <= lag_data[SW-1];
          state     <= B_RN_WAIT;
        end
        B_RN_WAIT: begin
          if (div_done) begin
            rn[i] <= neg ? -q_ext : q_ext;
            if (i == p) begin
              e     <= lpcac_pkg::ONE_Q30;
              i     <= IW'(1);
              state <= B_ACC_INIT;
            end else begin
              i     <= i + 1'b1;
              state <= B_RN_START;
            end
          end
        end
        B_ACC_INIT: begin
          acc   <= {{(SW - CW){rn_rd[CW-1]}}, rn_rd};
          j     <= IW'(1);
          state <= (i == IW'(1)) ? B_K_START : B_ACC_RD;
        end
        B_ACC_RD: state <= B_ACC_MUL;
        B_ACC_MUL: begin
          prod  <= rd_a * rn_rd;
          state <= B_ACC_ADD;
        end
        B_ACC_ADD: begin
          acc <= acc_add;
          if (j == IW'(i - 1'b1)) begin
            state <= B_K_START;
          end else begin
            j     <= j + 1'b1;
            state <= B_ACC_RD;
          end
        end
        B_K_START: begin
          if (acc_mag >= {{(SW - RW){1'b0}}, e}) begin
            state <= B_FAIL;
          end else begin
            div_num   <= acc_mag[QW-1:0];
            div_den   <= e;
            div_start <= 1'b1;
            neg       <= acc[SW-1];
            state     <= B_K_WAIT;
          end
        end
        B_K_WAIT: begin
          if (div_done) begin
            k     <= neg ? q_ext : -q_ext;
            j     <= IW'(1);
            state <= (i == IW'(1)) ? B_KI : B_UPD_RD;
          end
        end
        B_UPD_RD: state <= B_UPD_MUL;
        B_UPD_MUL: begin
          prod  <= k * rd_b;
          areg  <= rd_a;
          state <= B_UPD_ADD;
        end
        B_UPD_ADD: begin
          if (j == IW'(i - 1'b1)) begin
            state <= B_KI;
          end else begin
            j     <= j + 1'b1;
            state <= B_UPD_RD;
          end
        end
        B_KI: begin
          prod  <= k * k;
          state <= B_E1;
        end
        B_E1: begin
          pe    <= e * omk;
          state <= B_E2;
        end
        B_E2: begin
          if (pe[2*RW-1:30] == '0) begin
            state <= B_FAIL;
          end else begin
            e    <= pe[60:30];
            bank <= !bank;
            if (i == p) begin
              o     <= '0;
              state <= B_OUT;
            end else begin
              i     <= i + 1'b1;
              state <= B_ACC_INIT;
            end
          end
        end
        B_OUT: begin
          if (!out_valid) begin
            if (o == '0) begin
              coefficient    <= lpcac_pkg::ONE_Q24;
              coeff_index    <= '0;
              residual_error <= '0;
              status         <= 1'b0;
              last_result    <= 1'b0;
              out_valid      <= 1'b1;
              o              <= IW'(1);
            end else begin
              state <= B_OUT_LD;
            end
          end
        end
        B_OUT_LD: begin
          coefficient    <= rd_a;
          coeff_index    <= o;
          residual_error <= (o == p) ? e : '0;
          status         <= 1'b0;
          last_result    <= (o == p);
          out_valid      <= 1'b1;
          if (o == p) begin
            state <= B_IDLE;
          end else begin
            o     <= o + 1'b1;
            state <= B_OUT;
          end
        end
        B_FAIL: begin
          if (!out_valid) begin
            coefficient    <= '0;
            coeff_index    <= '0;
            residual_error <= '0;
            status         <= 1'b1;
            last_result    <= 1'b1;
            out_valid      <= 1'b1;
            state          <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> design/lpc_autocorrelation_analysis.sv
`timescale 1ns / 1ps
// LPC analysis: autocorrelation over a frame, then Levinson-Durbin recursion.
// Input queue: push a signed sample with frame_end marking the last one of the
// frame; a transfer happens when push is high and full is low. Each sample steps
// through accept, 17 lags on one shared 16x16 multiply-accumulate, the last add
// and the history shift. A frame end adds a hand-off step that gives the lag
// sums to the recursion engine, which then works while the next frame arrives;
// a second frame end waits until the engine has normalized the first one.
// Result queue: while empty is low the oldest result is on the ports; pop
// transfers it. A frame gives order+1 coefficients (index 0 first, 1.0 in
// Q8.24) with the residual error on the last, or one failure result.
// Recursion: up to 16 normalizing shifts, each lag divided on the shared 31-step
// divider, then per order step i an accumulate, a division for the reflection
// coefficient and the coefficient and error updates; results leave one at a
// time while pop keeps up. A stalled receiver holds the result register; the
// engine waits, the front keeps taking samples until its hand-off slot is full.
// Reset clears all control state and sets order to 10; sums and history are
// cleared at each frame start. Register order lies at byte address 0.
module lpc_autocorrelation_analysis (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [lpcac_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 frame_end,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [lpcac_pkg::COEF_W-1:0]  coefficient,
  output logic [lpcac_pkg::IDX_W-1:0]          coeff_index,
  output logic [lpcac_pkg::RES_W-1:0]          residual_error,
  output logic                                 status,
  output logic                                 last_result,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lpcac_pkg::ADDR_W-1:0]         paddr,
  input  logic [lpcac_pkg::REG_W-1:0]          pwdata,
  output logic [lpcac_pkg::REG_W-1:0]          prdata,
  output logic                                 pready
);

  logic [lpcac_pkg::IDX_W-1:0]        order;
  lpcac_pkg::job_t                    job;
  logic                               job_done;
  logic [lpcac_pkg::IDX_W-1:0]        lag_idx;
  logic signed [lpcac_pkg::SUM_W-1:0] lag_data;
  logic                               reg_sel;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[lpcac_pkg::ADDR_W-1:2] == lpcac_pkg::REG_ORDER);
  assign prdata  = reg_sel ? {{(lpcac_pkg::REG_W - lpcac_pkg::IDX_W){1'b0}}, order} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= lpcac_pkg::ORDER_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      order <= pwdata[lpcac_pkg::IDX_W-1:0];
    end
  end

  lpcac_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .frame_end (frame_end),
    .order     (order),
    .job       (job),
    .job_done  (job_done),
    .lag_idx   (lag_idx),
    .lag_data  (lag_data)
  );

  lpcac_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job            (job),
    .job_done       (job_done),
    .lag_idx        (lag_idx),
    .lag_data       (lag_data),
    .empty          (empty),
    .pop            (pop),
    .coefficient    (coefficient),
    .coeff_index    (coeff_index),
    .residual_error (residual_error),
    .status         (status),
    .last_result    (last_result)
  );

endmodule

>>> design/lpcac_checker.sv
`timescale 1ns / 1ps
`include "lpc_autocorrelation_analysis_macros.svh"
module lpcac_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 push,
  input logic                                 full,
  input logic signed [lpcac_pkg::SAMPLE_W-1:0] sample,
  input logic                                 frame_end,
  input logic                                 empty,
  input logic                                 pop,
  input logic signed [lpcac_pkg::COEF_W-1:0]  coefficient,
  input logic [lpcac_pkg::IDX_W-1:0]          coeff_index,
  input logic [lpcac_pkg::RES_W-1:0]          residual_error,
  input logic                                 status,
  input logic                                 last_result,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic [lpcac_pkg::ADDR_W-1:0]         paddr,
  input logic [lpcac_pkg::REG_W-1:0]          pwdata,
  input logic [lpcac_pkg::REG_W-1:0]          prdata,
  input logic                                 pready
);

  logic                                               fail_ok;
  logic                                               a0_ok;
  logic                                               stalled;
  logic [lpcac_pkg::COEF_W+lpcac_pkg::IDX_W-1:0]      res_word;

  // helper terms for the result checks
  assign fail_ok  = last_result && coefficient == '0 && coeff_index == '0
                 && residual_error == '0;
  assign a0_ok    = coefficient == lpcac_pkg::ONE_Q24 && !last_result;
  assign stalled  = !empty && !pop;
  assign res_word = {coefficient, coeff_index};

  // result queue is empty right after reset
  `LPCAC_ASSERT_RST(a_reset_empty, rst, empty, "result queue not empty after reset")

  // a failure is a single closing result with zero payload
  `LPCAC_ASSERT_IMP(a_fail_shape, !empty && status, fail_ok, "malformed failure result")

  // the first coefficient of a good frame is 1.0
  `LPCAC_ASSERT_IMP(a_a0_one, !empty && !status && coeff_index == '0, a0_ok, "a0 is not 1.0")

  // a waiting result holds until transferred
  `LPCAC_ASSERT_NXT(a_out_hold, stalled, !empty && $stable(res_word), "stalled result changed")

endmodule

bind lpc_autocorrelation_analysis lpcac_checker u_lpcac_checker (.*);
